// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/bfp_pkg.sv =====
// Shared types and constants for the bit-sliced Fitch parsimony block.
// No dependencies; used by the controller, datapath, top level and checker.
package bfp_pkg;

  localparam int WORD_BITS  = 32;  // sites per word
  localparam int SCORE_W    = 32;
  localparam int NS_W       = 6;   // state count register
  localparam int IDX_W      = 5;   // state_index field
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Slave tdata: left_bits, right_bits, left_score, right_score
  localparam int IN_TDATA_W = 2 * WORD_BITS + 2 * SCORE_W;

  // Master tdata: node_bits, state_index, score, subst_count (padded to bytes)
  localparam int OUT_NODE_LSB  = 0;
  localparam int OUT_IDX_LSB   = WORD_BITS;
  localparam int OUT_SCORE_LSB = OUT_IDX_LSB + IDX_W;
  localparam int OUT_SUBST_LSB = OUT_SCORE_LSB + SCORE_W;
  localparam int OUT_USED_W    = OUT_SUBST_LSB + SCORE_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W   = 2;  // score_valid, bound_hit
  localparam int TUSER_SV      = 0;
  localparam int TUSER_HIT     = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_N_STATES  = 2'd0,
    REG_MODE      = 2'd1,
    REG_LOWER_BND = 2'd2
  } cfg_reg_e;

  localparam logic MODE_COMBINE = 1'b0;
  localparam logic MODE_BRANCH  = 1'b1;

  localparam logic [NS_W-1:0]    N_STATES_RST = 6'd4;
  localparam logic [NS_W-1:0]    N_STATES_MIN = 6'd2;

  // Controller -> datapath
  typedef struct packed {
    logic accept;  // take the input word
    logic count;   // form miss mask and popcount
    logic score;   // update score, rewind emit pointer
    logic read;    // read store at emit pointer
    logic push;    // load output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic closes;     // incoming word closes a site word
    logic branch;     // branch mode
    logic end_word;   // closed site word carried vector_end
    logic emit_last;  // current emit is the last of the run
    logic out_free;   // output register can take a word
  } sts_t;

endpackage

// ===== hw/rtl/bfp_ctrl.sv =====
// Sequencing FSM for the bit-sliced Fitch parsimony block.
// Depends on bfp_pkg (cmd_t, sts_t).
module bfp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bfp_pkg::sts_t sts_i,
  output bfp_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COUNT = 5'b00010,
    S_SCORE = 5'b00100,
    S_READ  = 5'b01000,
    S_PUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.closes) state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.count = 1'b1;
        state_d     = S_SCORE;
      end
      S_SCORE: begin
        cmd_o.score = 1'b1;
        if (!sts_i.branch) state_d = S_READ;
        else if (sts_i.end_word) state_d = S_PUSH;
        else state_d = S_IDLE;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_PUSH;
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = sts_i.emit_last ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/bfp_datapath.sv =====
// Datapath: config registers, AND/OR store, score accumulation, output register.
// Depends on bfp_pkg; driven by bfp_ctrl through cmd_t / sts_t.
module bfp_datapath #(
  parameter int MAX_STATES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bfp_pkg::cmd_t                    cmd_i,
  output bfp_pkg::sts_t                    sts_o,
  // input word
  input  logic [bfp_pkg::WORD_BITS-1:0]    left_bits_i,
  input  logic [bfp_pkg::WORD_BITS-1:0]    right_bits_i,
  input  logic [bfp_pkg::SCORE_W-1:0]      left_score_i,
  input  logic [bfp_pkg::SCORE_W-1:0]      right_score_i,
  input  logic                             vector_start_i,
  input  logic                             vector_end_i,
  // config
  input  logic                             cfg_we_i,
  input  logic [bfp_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [bfp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // result word
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [bfp_pkg::WORD_BITS-1:0]    node_bits_o,
  output logic [bfp_pkg::IDX_W-1:0]        state_index_o,
  output logic                             run_last_o,
  output logic                             score_valid_o,
  output logic [bfp_pkg::SCORE_W-1:0]      score_o,
  output logic [bfp_pkg::SCORE_W-1:0]      subst_count_o,
  output logic                             bound_hit_o
);

  localparam int WB  = bfp_pkg::WORD_BITS;
  localparam int SW  = bfp_pkg::SCORE_W;
  localparam int CW  = $clog2(MAX_STATES);
  // wide enough for the state count and for state pointer + 1
  localparam int NW  = bfp_pkg::NS_W + 1;
  localparam int PCW = $clog2(WB + 1);

  // config
  logic [bfp_pkg::NS_W-1:0] n_states_q;
  logic                     mode_q;
  logic [SW-1:0]            bound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_states_q <= bfp_pkg::N_STATES_RST;
      mode_q     <= bfp_pkg::MODE_COMBINE;
      bound_q    <= '1;
    end else if (cfg_we_i) begin
      case (bfp_pkg::cfg_reg_e'(cfg_addr_i))
        bfp_pkg::REG_N_STATES:  n_states_q <= cfg_wdata_i[bfp_pkg::NS_W-1:0];
        bfp_pkg::REG_MODE:      mode_q     <= cfg_wdata_i[0];
        bfp_pkg::REG_LOWER_BND: bound_q    <= cfg_wdata_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // state
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [WB-1:0]   meet_q, meet_d;
  logic [SW-1:0]   acc_q, acc_d;
  logic [SW-1:0]   child_q, child_d;
  logic            stop_q, stop_d;
  logic [WB-1:0]   miss_q;
  logic [PCW-1:0]  pc_q;
  logic            end_q;
  logic [CW-1:0]   last_q;
  logic [CW-1:0]   emit_q;
  logic [2*WB-1:0] rd_q;
  logic [2*WB-1:0] store_mem [MAX_STATES];

  // incoming word
  logic [CW-1:0]   idx;
  logic [NW-1:0]   ns_ext, n_eff, idx_next;
  logic            closes;
  logic [WB-1:0]   and_w, or_w;
  logic [SW:0]     child_sum;
  logic [SW-1:0]   child_sat;

  always_comb begin
    idx       = vector_start_i ? '0 : cnt_q;
    ns_ext    = NW'(n_states_q);
    if (ns_ext < NW'(bfp_pkg::N_STATES_MIN)) n_eff = NW'(bfp_pkg::N_STATES_MIN);
    else if (ns_ext > NW'(MAX_STATES))       n_eff = NW'(MAX_STATES);
    else                                     n_eff = ns_ext;
    idx_next  = NW'(idx) + NW'(1);
    closes    = (idx_next >= n_eff) || vector_end_i;
    and_w     = left_bits_i & right_bits_i;
    or_w      = left_bits_i | right_bits_i;
    child_sum = {1'b0, left_score_i} + {1'b0, right_score_i};
    child_sat = child_sum[SW] ? '1 : child_sum[SW-1:0];
  end

  // popcount of the site miss mask: pair, nibble and byte sums, then bytes added
  localparam logic [WB-1:0] M1 = {(WB/2){2'b01}};
  localparam logic [WB-1:0] M2 = {(WB/4){4'b0011}};
  localparam logic [WB-1:0] M4 = {(WB/8){8'h0F}};
  logic [WB-1:0]  miss_w, pair_w, nib_w, byte_w;
  logic [PCW-1:0] pc_w;
  always_comb begin
    miss_w = ~meet_q;
    pair_w = miss_w - ((miss_w >> 1) & M1);
    nib_w  = (pair_w & M2) + ((pair_w >> 2) & M2);
    byte_w = (nib_w + (nib_w >> 4)) & M4;
    pc_w   = '0;
    for (int i = 0; i < WB / 8; i++) begin
      pc_w = pc_w + PCW'(byte_w[8*i +: 8]);
    end
  end

  // score update
  logic [SW:0]   add_w;
  logic [SW-1:0] add_sat;
  always_comb begin
    add_w   = {1'b0, acc_q} + (SW + 1)'(pc_q);
    add_sat = add_w[SW] ? '1 : add_w[SW-1:0];
  end

  always_comb begin
    cnt_d   = cnt_q;
    meet_d  = meet_q;
    acc_d   = acc_q;
    child_d = child_q;
    stop_d  = stop_q;
    if (cmd_i.accept) begin
      if (vector_start_i) begin
        child_d = child_sat;
        acc_d   = child_sat;
        stop_d  = 1'b0;
      end
      meet_d = ((idx == '0) ? '0 : meet_q) | and_w;
      cnt_d  = closes ? '0 : idx_next[CW-1:0];
    end
    if (cmd_i.score) begin
      if (mode_q == bfp_pkg::MODE_COMBINE) begin
        acc_d = add_sat;
      end else if (!stop_q) begin
        acc_d = add_sat;
        if ((bound_q != '1) && (add_sat >= bound_q)) stop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      acc_q   <= '0;
      child_q <= '0;
      stop_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      child_q <= child_d;
      stop_q  <= stop_d;
    end
  end

  // payload-only registers
  always_ff @(posedge clk_i) begin
    meet_q <= meet_d;
    if (cmd_i.accept && closes) begin
      last_q <= idx;
      end_q  <= vector_end_i;
    end
    if (cmd_i.count) begin
      miss_q <= miss_w;
      pc_q   <= pc_w;
    end
    if (cmd_i.score)     emit_q <= '0;
    else if (cmd_i.push) emit_q <= emit_q + CW'(1);
  end

  // AND/OR store: {or, and} per state
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) store_mem[idx] <= {or_w, and_w};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) rd_q <= store_mem[emit_q];
  end

  // output register
  logic          out_valid_q;
  logic [WB-1:0] node_q;
  logic [bfp_pkg::IDX_W-1:0] sidx_q;
  logic          last_out_q, sv_q, hit_q;
  logic [SW-1:0] score_q, subst_q;
  logic [63:0]   emit_ext;
  logic          emit_last;

  assign emit_ext  = 64'(emit_q);
  assign emit_last = (mode_q == bfp_pkg::MODE_BRANCH) || (emit_q == last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      if (mode_q == bfp_pkg::MODE_COMBINE) begin
        node_q     <= rd_q[WB-1:0] | (miss_q & rd_q[2*WB-1:WB]);
        sidx_q     <= emit_ext[bfp_pkg::IDX_W-1:0];
        last_out_q <= (emit_q == last_q);
        sv_q       <= end_q;
        score_q    <= end_q ? acc_q : '0;
        subst_q    <= end_q ? (acc_q - child_q) : '0;
        hit_q      <= 1'b0;
      end else begin
        node_q     <= '0;
        sidx_q     <= '0;
        last_out_q <= 1'b1;
        sv_q       <= 1'b1;
        score_q    <= acc_q;
        subst_q    <= acc_q - child_q;
        hit_q      <= stop_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign node_bits_o   = node_q;
  assign state_index_o = sidx_q;
  assign run_last_o    = last_out_q;
  assign score_valid_o = sv_q;
  assign score_o       = score_q;
  assign subst_count_o = subst_q;
  assign bound_hit_o   = hit_q;

  assign sts_o.closes    = closes;
  assign sts_o.branch    = (mode_q == bfp_pkg::MODE_BRANCH);
  assign sts_o.end_word  = end_q;
  assign sts_o.emit_last = emit_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/bitsliced_fitch_parsimony.sv =====
// Bit-sliced Fitch parsimony: one state word per input word, 32 sites each.
// A word that does not close a site word is only accepted; a closing word is accepted,
// then popcount, then score add, then a store read and output load per combined word
// out, or just an output load for the branch totals word, plus any output stall.
// No new input word is accepted until a closing word has finished all of these steps.
// Reset (async, active low) clears control, counters, scores; config to defaults.
module bitsliced_fitch_parsimony #(
  parameter int MAX_STATES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // left_bits[31:0], right_bits[63:32], left_score[95:64], right_score[127:96]
  input  logic [bfp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,  // vector_end
  input  logic                                s_axis_tuser,  // vector_start
  // result words
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // node_bits[31:0], state_index[36:32], score[68:37], subst_count[100:69], pad
  output logic [bfp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,  // run_last
  // score_valid[0], bound_hit[1]
  output logic [bfp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [bfp_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [bfp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int WB = bfp_pkg::WORD_BITS;
  localparam int SW = bfp_pkg::SCORE_W;

  bfp_pkg::cmd_t cmd;
  bfp_pkg::sts_t sts;

  logic [WB-1:0]             node_bits;
  logic [bfp_pkg::IDX_W-1:0] state_index;
  logic [SW-1:0]             score, subst_count;
  logic                      score_valid, bound_hit;

  bfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfp_datapath #(
    .MAX_STATES (MAX_STATES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .left_bits_i    (s_axis_tdata[WB-1:0]),
    .right_bits_i   (s_axis_tdata[2*WB-1:WB]),
    .left_score_i   (s_axis_tdata[2*WB+SW-1:2*WB]),
    .right_score_i  (s_axis_tdata[2*WB+2*SW-1:2*WB+SW]),
    .vector_start_i (s_axis_tuser),
    .vector_end_i   (s_axis_tlast),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .node_bits_o    (node_bits),
    .state_index_o  (state_index),
    .run_last_o     (m_axis_tlast),
    .score_valid_o  (score_valid),
    .score_o        (score),
    .subst_count_o  (subst_count),
    .bound_hit_o    (bound_hit)
  );

  // pack result fields, lowest field first, zero pad to bytes
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[bfp_pkg::OUT_NODE_LSB +: WB]            = node_bits;
    m_axis_tdata[bfp_pkg::OUT_IDX_LSB +: bfp_pkg::IDX_W] = state_index;
    m_axis_tdata[bfp_pkg::OUT_SCORE_LSB +: SW]           = score;
    m_axis_tdata[bfp_pkg::OUT_SUBST_LSB +: SW]           = subst_count;
    m_axis_tuser[bfp_pkg::TUSER_SV]  = score_valid;
    m_axis_tuser[bfp_pkg::TUSER_HIT] = bound_hit;
  end

endmodule

// ===== hw/rtl/bfp_checker.sv =====
// Port-level checks on the result stream of bitsliced_fitch_parsimony, and bind.
// Depends on bfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bfp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic [bfp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int SW = bfp_pkg::SCORE_W;

  logic [SW-1:0] score_w, subst_w;
  logic          sv_w, hit_w;

  assign score_w = m_axis_tdata[bfp_pkg::OUT_SCORE_LSB +: SW];
  assign subst_w = m_axis_tdata[bfp_pkg::OUT_SUBST_LSB +: SW];
  assign sv_w    = m_axis_tuser[bfp_pkg::TUSER_SV];
  assign hit_w   = m_axis_tuser[bfp_pkg::TUSER_HIT];

  // stalled word holds
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // bound hit only on a final totals word
  `ASSERT_IMPL(a_hit_sv, clk_i, rst_ni, m_axis_tvalid && hit_w, sv_w)

  // totals are zero until the vector ends
  `ASSERT_IMPL(a_score_zero, clk_i, rst_ni, m_axis_tvalid && !sv_w, score_w == '0 && subst_w == '0)

  // subst_count never exceeds the total score
  `ASSERT_IMPL(a_subst_le, clk_i, rst_ni, m_axis_tvalid, subst_w <= score_w)

endmodule

bind bitsliced_fitch_parsimony bfp_checker u_bfp_checker (.*);

// ===== tb/fitch_sb_pkg.sv =====
`timescale 1ns / 100ps
// Word types and the scoreboard for the bit-sliced Fitch parsimony bench.
// Depends on bfp_pkg for register codes, mode codes and the state count reset.
package fitch_sb_pkg;
  import bfp_pkg::*;

  typedef struct {
    logic [31:0] left_bits;
    logic [31:0] right_bits;
    logic [31:0] left_score;
    logic [31:0] right_score;
    bit          vec_start;
    bit          vec_end;
  } state_word_t;

  typedef struct {
    logic [31:0] node_bits;
    logic [4:0]  state_index;
    bit          run_last;
    bit          score_valid;
    logic [31:0] score;
    logic [31:0] subst_count;
    bit          bound_hit;
  } node_word_t;

  class fitch_scoreboard;
    logic [NS_W-1:0] ns_cfg;
    logic            mode;
    logic [31:0]     bound_lim;
    logic [31:0]     and_mem [32];
    logic [31:0]     or_mem [32];
    int unsigned     st_cnt;
    logic [31:0]     acc;
    logic [31:0]     child_sum;
    bit              stopped;
    node_word_t      due_q [$];
    int              errors;
    int              reported;

    function new();
      ns_cfg      = N_STATES_RST;
      mode        = MODE_COMBINE;
      bound_lim   = '1;
      st_cnt      = 0;
      acc         = '0;
      child_sum   = '0;
      stopped     = 1'b0;
      errors      = 0;
      reported    = 0;
      foreach (and_mem[i]) begin
        and_mem[i] = '0;
        or_mem[i]  = '0;
      end
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        REG_N_STATES:  ns_cfg    = val[NS_W-1:0];
        REG_MODE:      mode      = val[0];
        REG_LOWER_BND: bound_lim = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void push_due(logic [31:0] bits, int unsigned idx, bit last, bit valid,
                           bit hit);
      node_word_t r;
      r.node_bits   = bits;
      r.state_index = idx[4:0];
      r.run_last    = last;
      r.score_valid = valid;
      r.score       = valid ? acc : '0;
      r.subst_count = valid ? acc - child_sum : '0;
      r.bound_hit   = valid ? hit : 1'b0;
      due_q.insert(due_q.size(), r);
    endfunction

    // Fitch step for one accepted state word; queues the node words it yields.
    function void take_state_word(state_word_t w);
      int unsigned n;
      int unsigned slot;
      int unsigned k;
      logic [31:0] meet;
      logic [31:0] miss;
      logic [31:0] pc;
      if (w.vec_start) begin
        st_cnt    = 0;
        child_sum = sat_add(w.left_score, w.right_score);
        acc       = child_sum;
        stopped   = 1'b0;
      end
      n = ns_cfg;
      if (n < 2) n = 2;
      if (n > 32) n = 32;
      slot = (st_cnt >= 32) ? 31 : st_cnt;
      and_mem[slot] = w.left_bits & w.right_bits;
      or_mem[slot]  = w.left_bits | w.right_bits;
      if (slot + 1 < n && !w.vec_end) begin
        st_cnt = slot + 1;
        return;
      end
      // site word closes
      k      = slot + 1;
      st_cnt = 0;
      meet   = '0;
      for (int unsigned i = 0; i < k; i++) meet |= and_mem[i];
      miss = ~meet;
      pc   = $countones(miss);
      if (mode == MODE_COMBINE) begin
        acc = sat_add(acc, pc);
        for (int unsigned i = 0; i < k; i++)
          push_due(and_mem[i] | (miss & or_mem[i]), i, i + 1 == k, w.vec_end, 1'b0);
        return;
      end
      if (!stopped) begin
        acc = sat_add(acc, pc);
        if (bound_lim != 32'hFFFF_FFFF && acc >= bound_lim) stopped = 1'b1;
      end
      if (w.vec_end) push_due('0, 0, 1'b1, 1'b1, stopped);
    endfunction

    function void check_node_word(node_word_t got);
      node_word_t exp;
      if (due_q.size() == 0) begin
        errors++;
        if (reported < 10)
          $display("unexpected node word: bits %h idx %0d score %h", got.node_bits,
                   got.state_index, got.score);
        reported++;
        return;
      end
      exp = due_q.pop_front();
      if (exp.node_bits !== got.node_bits || exp.state_index !== got.state_index ||
          exp.run_last !== got.run_last || exp.score_valid !== got.score_valid ||
          exp.score !== got.score || exp.subst_count !== got.subst_count ||
          exp.bound_hit !== got.bound_hit) begin
        errors++;
        if (reported < 10) begin
          $display("node word mismatch (bits idx last valid score subst hit)");
          $display("  exp %h %0d %b %b %h %h %b", exp.node_bits, exp.state_index,
                   exp.run_last, exp.score_valid, exp.score, exp.subst_count,
                   exp.bound_hit);
          $display("  got %h %0d %b %b %h %h %b", got.node_bits, got.state_index,
                   got.run_last, got.score_valid, got.score, got.subst_count,
                   got.bound_hit);
        end
        reported++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

endpackage

// ===== tb/bitsliced_fitch_parsimony_tb.sv =====
`timescale 1ns / 100ps
// Top-level bench for bitsliced_fitch_parsimony: directed and random state words.
// Depends on bfp_pkg (ports, codes) and fitch_sb_pkg (scoreboard).
module bitsliced_fitch_parsimony_tb;
  import bfp_pkg::*;
  import fitch_sb_pkg::*;

  // A closing word can emit up to 32 node words, each held up by random result stalls;
  // this limit lies far above the worst such run.
  localparam int CYCLE_LIMIT = 2000000;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // left_bits, right_bits, left_score, right_score (low bits first)
  logic [IN_TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                     s_axis_tlast  = 1'b0;  // vector_end
  logic                     s_axis_tuser  = 1'b0;  // vector_start
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // node_bits, state_index, score, subst_count, pad (low bits first)
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                     m_axis_tlast;          // run_last
  // score_valid, bound_hit (low bit first)
  logic [OUT_TUSER_W-1:0]   m_axis_tuser;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]    cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i   = '0;

  fitch_scoreboard sb;
  bit              idling = 1'b1;  // random gaps/stalls on both sides
  int              items_sent = 0;
  int              cycles = 0;

  bitsliced_fitch_parsimony u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hang or a lost word ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check every accepted word, then pick tready for the next edge.
  // Sampling right at the edge sees pre-edge values since all drives are NBAs.
  always @(posedge clk_i) begin : rx_side
    node_word_t got;
    int         stall_left;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.node_bits   = m_axis_tdata[OUT_NODE_LSB +: WORD_BITS];
      got.state_index = m_axis_tdata[OUT_IDX_LSB +: IDX_W];
      got.score       = m_axis_tdata[OUT_SCORE_LSB +: SCORE_W];
      got.subst_count = m_axis_tdata[OUT_SUBST_LSB +: SCORE_W];
      got.run_last    = m_axis_tlast;
      got.score_valid = m_axis_tuser[TUSER_SV];
      got.bound_hit   = m_axis_tuser[TUSER_HIT];
      sb.check_node_word(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Drive one state word and hold it until accepted. tvalid stays high on
  // return so back-to-back words never drop it within one step.
  task automatic send_state_word(input state_word_t w);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.right_score, w.left_score, w.right_bits, w.left_bits};
    s_axis_tlast  <= w.vec_end;
    s_axis_tuser  <= w.vec_start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_state_word(w);
    items_sent++;
  endtask

  task automatic send_bits(input logic [31:0] l, input logic [31:0] r,
                           input logic [31:0] ls, input logic [31:0] rs,
                           input bit vs, input bit ve);
    state_word_t w;
    w.left_bits   = l;
    w.right_bits  = r;
    w.left_score  = ls;
    w.right_score = rs;
    w.vec_start   = vs;
    w.vec_end     = ve;
    send_state_word(w);
  endtask

  // Stop the input side and wait until every queued node word has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // words that queue no node word may still be in flight; this wait covers them
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(input logic [NS_W-1:0] ns, input logic md,
                            input logic [31:0] bnd);
    write_reg(REG_N_STATES, 32'(ns));
    write_reg(REG_MODE, 32'(md));
    write_reg(REG_LOWER_BND, bnd);
    cfg_we_i <= 1'b0;
  endtask

  // Mix of dense, sparse and extreme per-state site words.
  function automatic logic [31:0] site_bits();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1, 2:    return $urandom & $urandom;
      3:       return $urandom & $urandom & $urandom;
      4:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  // Mostly small child scores so the bound matters; some near saturation.
  function automatic logic [31:0] child_score();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // One vector of whole site words, sometimes cut short by an early vector_end,
  // sometimes without vector_start so the running score just carries on.
  task automatic send_vector(input int unsigned n_eff);
    int unsigned words;
    int unsigned total;
    int unsigned cut;
    bit          has_start;
    logic [31:0] ls;
    logic [31:0] rs;
    words     = (n_eff >= 16) ? $urandom_range(1, 2) : $urandom_range(1, 4);
    total     = n_eff * words;
    cut       = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
    has_start = ($urandom_range(0, 7) != 0);
    ls        = child_score();
    rs        = child_score();
    for (int unsigned i = 0; i < cut; i++)
      send_bits(site_bits(), site_bits(), (i == 0) ? ls : $urandom,
                (i == 0) ? rs : $urandom, has_start && i == 0, i + 1 == cut);
  endtask

  // One configuration phase. Noise words with stray flags go in front of some
  // vectors; every phase ends on vector_end so the state count is back at zero.
  task automatic run_phase(input logic [NS_W-1:0] ns, input logic md,
                           input logic [31:0] bnd, input int n_items, input bit quiet);
    int          goal;
    int unsigned n_eff;
    idling = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    set_config(ns, md, bnd);
    n_eff = (ns < 2) ? 2 : (ns > 32) ? 32 : ns;
    goal  = items_sent + n_items;
    while (items_sent < goal) begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3))
          send_bits(site_bits(), site_bits(), child_score(), child_score(),
                    $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
      send_vector(n_eff);
    end
    settle();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset config: 4 states, combine, no bound ---
    // saturating child sum; every site meets, so no substitutions
    send_bits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1'b1, 1'b0);
    send_bits(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    send_bits(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    send_bits(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1);
    // disjoint children: 32 per word; second word cut after one state
    for (int i = 0; i < 5; i++)
      send_bits(32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h0, i == 0, i == 4);
    // one-word vector: start and end on the same word
    send_bits(32'h0000_FFFF, 32'h00FF_00FF, 32'd5, 32'd7, 1'b1, 1'b1);
    // no vector_start: score carries on from the last vector
    for (int i = 0; i < 4; i++)
      send_bits($urandom, $urandom, 32'h0, 32'h0, 1'b0, i == 3);
    // score runs into saturation from a high child sum
    for (int i = 0; i < 4; i++)
      send_bits(32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FFF0, 32'h0, i == 0, i == 3);
    settle();

    // --- directed branch mode: bound 40, two states per word ---
    // 5 + 32 = 37 stays under, 69 crosses and stops, third word adds nothing
    set_config(6'd2, MODE_BRANCH, 32'd40);
    for (int i = 0; i < 6; i++)
      send_bits(32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'd2, 32'd3, i == 0, i == 5);
    settle();

    // --- random phases across settings, extremes included ---
    run_phase(6'd2,  MODE_COMBINE, 32'hFFFF_FFFF, 70, 1'b0);
    run_phase(6'd3,  MODE_COMBINE, 32'h0,         60, 1'b0);
    run_phase(6'd32, MODE_COMBINE, 32'hFFFF_FFFF, 40, 1'b0);
    run_phase(6'd0,  MODE_COMBINE, 32'hFFFF_FFFF, 30, 1'b0);  // clamps up to 2
    run_phase(6'd63, MODE_BRANCH,  32'hFFFF_FFFF, 40, 1'b0);  // clamps down to 32
    run_phase(6'd1,  MODE_BRANCH,  32'h0,         30, 1'b0);  // stops on first word
    run_phase(6'd5,  MODE_BRANCH,  $urandom_range(20, 200), 80, 1'b0);
    run_phase(6'd8,  MODE_BRANCH,  32'hFFFF_FFFE, 40, 1'b0);
    run_phase(6'd4,  MODE_COMBINE, 32'hFFFF_FFFF, 60, 1'b1);  // no idling at the end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bfp_pkg.sv
hw/rtl/bfp_ctrl.sv
hw/rtl/bfp_datapath.sv
hw/rtl/bitsliced_fitch_parsimony.sv
hw/rtl/bfp_checker.sv
tb/fitch_sb_pkg.sv
tb/bitsliced_fitch_parsimony_tb.sv
